// ===== hdl/lppe_pkg.sv =====
// ----------------------------------------------------------------------------
// lppe_pkg
// Shared types, widths, register map and reset values of the pixel encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package lppe_pkg;

  localparam int BITS_PER_PIXEL = 24;   // pulse pairs per pixel, 24..32
  localparam int COLOR_BITS     = 24;   // G,R,B bytes
  localparam int CHAN_W         = 8;
  localparam int TICK_W         = 15;
  localparam int ADDR_W         = 5;
  localparam int DATA_W         = 32;
  localparam int REG_IDX_W      = 3;

  // register indexes, byte address is 4*index
  localparam logic [REG_IDX_W-1:0] REG_BRIGHTNESS = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ZERO_HIGH  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ZERO_LOW   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ONE_HIGH   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ONE_LOW    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_LATCH      = 3'd5;

  localparam logic [CHAN_W-1:0] RST_BRIGHTNESS = 8'd25;
  localparam logic [TICK_W-1:0] RST_ZERO_HIGH  = 15'd7;
  localparam logic [TICK_W-1:0] RST_ZERO_LOW   = 15'd18;
  localparam logic [TICK_W-1:0] RST_ONE_HIGH   = 15'd18;
  localparam logic [TICK_W-1:0] RST_ONE_LOW    = 15'd7;
  localparam logic [TICK_W-1:0] RST_LATCH      = 15'd1000;

  typedef struct packed {
    logic [CHAN_W-1:0] brightness;
    logic [TICK_W-1:0] zero_high;
    logic [TICK_W-1:0] zero_low;
    logic [TICK_W-1:0] one_high;
    logic [TICK_W-1:0] one_low;
    logic [TICK_W-1:0] latch;
  } cfg_t;

  // scaled pixel waiting to be loaded into the chain
  typedef struct packed {
    logic                  valid;
    logic [COLOR_BITS-1:0] word;
    logic                  last;
  } scaled_t;

  // contents of one chain cell
  typedef struct packed {
    logic valid;
    logic data;
    logic run_end;
    logic latch;
  } cell_t;

endpackage

`default_nettype wire

// ===== hdl/lppe_pixel_if.sv =====
// ----------------------------------------------------------------------------
// lppe_pixel_if
// Pixel channel: valid/ready plus red, green, blue and last-pixel flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface lppe_pixel_if;
  logic                        valid;
  logic                        ready;
  logic [lppe_pkg::CHAN_W-1:0] red;
  logic [lppe_pkg::CHAN_W-1:0] green;
  logic [lppe_pkg::CHAN_W-1:0] blue;
  logic                        last_pixel;

  modport source (output valid, red, green, blue, last_pixel, input ready);
  modport sink   (input valid, red, green, blue, last_pixel, output ready);
endinterface

`default_nettype wire

// ===== hdl/lppe_pulse_if.sv =====
// ----------------------------------------------------------------------------
// lppe_pulse_if
// Pulse pair channel: valid/ready plus tick counts, bit and run end flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface lppe_pulse_if;
  logic                        valid;
  logic                        ready;
  logic [lppe_pkg::TICK_W-1:0] high_ticks;
  logic [lppe_pkg::TICK_W-1:0] low_ticks;
  logic                        bit_value;
  logic                        run_end;

  modport source (output valid, high_ticks, low_ticks, bit_value, run_end, input ready);
  modport sink   (input valid, high_ticks, low_ticks, bit_value, run_end, output ready);
endinterface

`default_nettype wire

// ===== hdl/led_pixel_pulse_encoder.sv =====
// ----------------------------------------------------------------------------
// led_pixel_pulse_encoder
// Scales an RGB pixel by brightness and emits its LED line pulse pairs.
// ----------------------------------------------------------------------------
// A pixel transaction is scaled ((c*brightness)>>8 per channel) into a
// register, then loaded in parallel into a chain of BITS_PER_PIXEL cells, one
// per pulse pair, G,R,B order, MSB first. The head cell is the output
// register; each accepted pulse transaction shifts the chain one cell toward
// the head. One pulse pair leaves per cycle while the pulse side is ready,
// and a pixel occupies the chain for BITS_PER_PIXEL pulse pairs with no gap
// between runs: the next pixel loads as the last pulse of the current one
// is taken, and a further pixel waits in the scale register meanwhile.
// Into an idle block, the first pulse of a pixel is offered once its
// transaction has passed the scale register and then the chain load. Tick
// counts come from the configuration registers; the final pulse of a pixel
// flagged last carries latch_ticks as its low time. Registers sit at byte
// address 4*index and must only be written while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module led_pixel_pulse_encoder (
  input  wire logic                        clk,
  input  wire logic                        rst,
  lppe_pixel_if.sink                       pix,
  lppe_pulse_if.source                     pulse,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [lppe_pkg::ADDR_W-1:0] paddr,
  input  wire logic [lppe_pkg::DATA_W-1:0] pwdata,
  output logic      [lppe_pkg::DATA_W-1:0] prdata,
  output logic                             pready
);
  import lppe_pkg::*;

  localparam int N = BITS_PER_PIXEL;

  cfg_t    cfg;
  scaled_t sc;
  cell_t   chain [N];
  cell_t   head;
  logic    shift;
  logic    load;

  lppe_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lppe_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .brightness (cfg.brightness),
    .pix        (pix),
    .take       (load),
    .sc         (sc)
  );

  assign head  = chain[0];
  assign shift = pulse.valid & pulse.ready;
  // load into an empty chain, or as its only remaining pulse leaves
  assign load  = sc.valid & (~head.valid | (shift & ~chain[1].valid));

  genvar i;
  generate
    for (i = 0; i < N; i++) begin : g_cell
      cell_t load_d;
      cell_t next_d;

      assign load_d.valid   = 1'b1;
      assign load_d.run_end = (i == N - 1);
      assign load_d.latch   = (i == N - 1) & sc.last;
      if (i < COLOR_BITS) begin : g_data
        assign load_d.data = sc.word[COLOR_BITS-1-i];
      end else begin : g_pad
        // pulses past the blue byte send zero bits
        assign load_d.data = 1'b0;
      end

      if (i == N - 1) begin : g_tail
        assign next_d = '0;
      end else begin : g_link
        assign next_d = chain[i+1];
      end

      lppe_cell u_cell (
        .clk    (clk),
        .rst    (rst),
        .load   (load),
        .shift  (shift),
        .load_d (load_d),
        .next_d (next_d),
        .q      (chain[i])
      );
    end
  endgenerate

  // payload from the head cell; the user must keep config static while pulses are in flight (not enforced here)
  assign pulse.valid      = head.valid;
  assign pulse.bit_value  = head.data;
  assign pulse.run_end    = head.run_end;
  assign pulse.high_ticks = head.data ? cfg.one_high : cfg.zero_high;
  assign pulse.low_ticks  = head.latch ? cfg.latch :
                            (head.data ? cfg.one_low : cfg.zero_low);

  // valid cells stay packed at the head of the chain
  a_packed: assert property (@(posedge clk) disable iff (rst)
    !chain[0].valid |-> !chain[1].valid)
    else $error("chain has a hole at the head");

  // a run end pulse is the last valid cell
  a_end_alone: assert property (@(posedge clk) disable iff (rst)
    (chain[0].valid && chain[0].run_end) |-> !chain[1].valid)
    else $error("run end pulse with pulses behind it");

  // a load fills the whole chain, tail included
  a_load_full: assert property (@(posedge clk) disable iff (rst)
    load |=> (chain[N-1].valid && chain[N-1].run_end && chain[0].valid))
    else $error("load did not fill the chain");

  // the latch time only rides on a run end pulse
  a_latch_end: assert property (@(posedge clk) disable iff (rst)
    (chain[0].valid && chain[0].latch) |-> chain[0].run_end)
    else $error("latch time on a pulse other than the run end");

endmodule

`default_nettype wire

// ===== hdl/lppe_regs.sv =====
// ----------------------------------------------------------------------------
// lppe_regs
// APB-style configuration registers, write and read back.
// ----------------------------------------------------------------------------
`default_nettype none

module lppe_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [lppe_pkg::ADDR_W-1:0] paddr,
  input  wire logic [lppe_pkg::DATA_W-1:0] pwdata,
  output logic      [lppe_pkg::DATA_W-1:0] prdata,
  output logic                             pready,
  output lppe_pkg::cfg_t                   cfg
);
  import lppe_pkg::*;

  logic                 wr_en;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.brightness <= RST_BRIGHTNESS;
      cfg.zero_high  <= RST_ZERO_HIGH;
      cfg.zero_low   <= RST_ZERO_LOW;
      cfg.one_high   <= RST_ONE_HIGH;
      cfg.one_low    <= RST_ONE_LOW;
      cfg.latch      <= RST_LATCH;
    end else if (wr_en) begin
      case (idx)
        REG_BRIGHTNESS: cfg.brightness <= pwdata[CHAN_W-1:0];
        REG_ZERO_HIGH:  cfg.zero_high  <= pwdata[TICK_W-1:0];
        REG_ZERO_LOW:   cfg.zero_low   <= pwdata[TICK_W-1:0];
        REG_ONE_HIGH:   cfg.one_high   <= pwdata[TICK_W-1:0];
        REG_ONE_LOW:    cfg.one_low    <= pwdata[TICK_W-1:0];
        REG_LATCH:      cfg.latch      <= pwdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_BRIGHTNESS: prdata = DATA_W'(cfg.brightness);
      REG_ZERO_HIGH:  prdata = DATA_W'(cfg.zero_high);
      REG_ZERO_LOW:   prdata = DATA_W'(cfg.zero_low);
      REG_ONE_HIGH:   prdata = DATA_W'(cfg.one_high);
      REG_ONE_LOW:    prdata = DATA_W'(cfg.one_low);
      REG_LATCH:      prdata = DATA_W'(cfg.latch);
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/lppe_scale.sv =====
// ----------------------------------------------------------------------------
// lppe_scale
// Brightness scaling stage: three 8x8 products, registered as a G,R,B word.
// ----------------------------------------------------------------------------
`default_nettype none

module lppe_scale (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [lppe_pkg::CHAN_W-1:0] brightness,
  lppe_pixel_if.sink                       pix,
  input  wire logic                        take,
  output lppe_pkg::scaled_t                sc
);
  import lppe_pkg::*;

  localparam int PROD_W = 2 * CHAN_W;

  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] prod_g;
  logic [PROD_W-1:0] prod_b;
  logic              acc;

  assign prod_r    = PROD_W'(pix.red)   * PROD_W'(brightness);
  assign prod_g    = PROD_W'(pix.green) * PROD_W'(brightness);
  assign prod_b    = PROD_W'(pix.blue)  * PROD_W'(brightness);
  assign pix.ready = ~sc.valid | take;
  assign acc       = pix.valid & pix.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sc.valid <= 1'b0;
    end else if (acc) begin
      sc.valid <= 1'b1;
    end else if (take) begin
      sc.valid <= 1'b0;
    end
    if (acc) begin
      // (c*b)>>8 keeps the upper byte of each product
      sc.word <= {prod_g[PROD_W-1:CHAN_W], prod_r[PROD_W-1:CHAN_W],
                  prod_b[PROD_W-1:CHAN_W]};
      sc.last <= pix.last_pixel;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lppe_cell.sv =====
// ----------------------------------------------------------------------------
// lppe_cell
// One cell of the pulse chain: parallel load, otherwise shift toward head.
// ----------------------------------------------------------------------------
`default_nettype none

module lppe_cell (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  wire logic          shift,
  input  wire lppe_pkg::cell_t load_d,
  input  wire lppe_pkg::cell_t next_d,
  output lppe_pkg::cell_t    q
);
  import lppe_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (load) begin
      q <= load_d;
    end else if (shift) begin
      q <= next_d;
    end
  end

endmodule

`default_nettype wire

// ===== tb/led_pixel_pulse_encoder_tb.sv =====
// ----------------------------------------------------------------------------
// led_pixel_pulse_encoder_tb
// Self-checking bench for the LED pixel pulse encoder.
// ----------------------------------------------------------------------------
// Pixels go in on the pixel channel. A ledger class keeps a copy of the six
// configuration registers and turns every accepted pixel into its 24 expected
// pulse pairs. Each pulse transaction taken from the block is matched in
// order against the oldest expected pair. Register settings change only
// while the block is drained. Both channel ends insert random idle cycles.
// One phase holds the pulse side off for a long stretch so that the pixel
// side backs up.
// ----------------------------------------------------------------------------

module led_pixel_pulse_encoder_tb;
  import lppe_pkg::*;

  // spare register slots past the end of the map: writes there do nothing
  localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_PIXELS  = 54;
  localparam int LONG_HOLD     = 200;     // receiver hold-off, in cycles

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              last_pixel;
  } pixel_t;

  typedef struct packed {
    logic [TICK_W-1:0] high_ticks;
    logic [TICK_W-1:0] low_ticks;
    logic              bit_value;
    logic              run_end;
  } pulse_t;

  // one expected pulse pair, tagged with where it comes from
  typedef struct {
    pulse_t pulse;
    int     pixel_no;
    int     bit_no;
  } pulse_due_t;

  // --------------------------------------------------------------------------
  // Pulse ledger: register copy, pixel encoding and in-order pulse matching
  // --------------------------------------------------------------------------
  class pulse_ledger;
    cfg_t       regs;
    pulse_due_t due_pulses[$];
    int         mismatches;
    int         pixels;
    int         latched;
    int         pulses;

    function new();
      regs.brightness = RST_BRIGHTNESS;
      regs.zero_high  = RST_ZERO_HIGH;
      regs.zero_low   = RST_ZERO_LOW;
      regs.one_high   = RST_ONE_HIGH;
      regs.one_low    = RST_ONE_LOW;
      regs.latch      = RST_LATCH;
    endfunction

    // only the low bits of a register survive; spare slots are ignored
    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      case (idx)
        REG_BRIGHTNESS: regs.brightness = data[CHAN_W-1:0];
        REG_ZERO_HIGH:  regs.zero_high  = data[TICK_W-1:0];
        REG_ZERO_LOW:   regs.zero_low   = data[TICK_W-1:0];
        REG_ONE_HIGH:   regs.one_high   = data[TICK_W-1:0];
        REG_ONE_LOW:    regs.one_low    = data[TICK_W-1:0];
        REG_LATCH:      regs.latch      = data[TICK_W-1:0];
        default: ;
      endcase
    endfunction

    // spare slots read as zero
    function logic [DATA_W-1:0] read_reg(logic [REG_IDX_W-1:0] idx);
      case (idx)
        REG_BRIGHTNESS: return DATA_W'(regs.brightness);
        REG_ZERO_HIGH:  return DATA_W'(regs.zero_high);
        REG_ZERO_LOW:   return DATA_W'(regs.zero_low);
        REG_ONE_HIGH:   return DATA_W'(regs.one_high);
        REG_ONE_LOW:    return DATA_W'(regs.one_low);
        REG_LATCH:      return DATA_W'(regs.latch);
        default:        return '0;
      endcase
    endfunction

    function logic [CHAN_W-1:0] dim(logic [CHAN_W-1:0] c);
      logic [2*CHAN_W-1:0] prod;
      prod = c * regs.brightness;
      return prod[2*CHAN_W-1:CHAN_W];
    endfunction

    // G,R,B order, MSB first; pairs past the color bits carry zeros
    function void log_pixel(pixel_t px);
      logic [COLOR_BITS-1:0] word;
      pulse_due_t            d;
      word = {dim(px.green), dim(px.red), dim(px.blue)};
      for (int k = 0; k < BITS_PER_PIXEL; k++) begin
        d.pulse.bit_value = 1'b0;
        if (k < COLOR_BITS) d.pulse.bit_value = word[COLOR_BITS-1-k];
        d.pulse.run_end    = (k == BITS_PER_PIXEL - 1);
        d.pulse.high_ticks = d.pulse.bit_value ? regs.one_high : regs.zero_high;
        d.pulse.low_ticks  = d.pulse.bit_value ? regs.one_low  : regs.zero_low;
        if (d.pulse.run_end && px.last_pixel) d.pulse.low_ticks = regs.latch;
        d.pixel_no = pixels;
        d.bit_no   = k;
        due_pulses.push_back(d);
      end
      pixels++;
      if (px.last_pixel) latched++;
    endfunction

    task report(string msg);
      mismatches++;
      $display("MISMATCH %0t: %s", $time, msg);
    endtask

    task match_pulse(pulse_t got);
      pulse_due_t want;
      string      where;
      pulses++;
      if (due_pulses.size() == 0) begin
        report($sformatf("unexpected pulse transaction %p", got));
        return;
      end
      want  = due_pulses.pop_front();
      where = $sformatf("pixel %0d pulse %0d", want.pixel_no, want.bit_no);
      if (got.high_ticks !== want.pulse.high_ticks)
        report($sformatf("%s high_ticks %0d, want %0d", where,
                         got.high_ticks, want.pulse.high_ticks));
      if (got.low_ticks !== want.pulse.low_ticks)
        report($sformatf("%s low_ticks %0d, want %0d", where,
                         got.low_ticks, want.pulse.low_ticks));
      if (got.bit_value !== want.pulse.bit_value)
        report($sformatf("%s bit_value %b, want %b", where,
                         got.bit_value, want.pulse.bit_value));
      if (got.run_end !== want.pulse.run_end)
        report($sformatf("%s run_end %b, want %b", where,
                         got.run_end, want.pulse.run_end));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  lppe_pixel_if pix_ch ();
  lppe_pulse_if pulse_ch ();

  led_pixel_pulse_encoder dut (
    .clk     (clk),
    .rst     (rst),
    .pix     (pix_ch),
    .pulse   (pulse_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk = ~clk;

  pulse_ledger ledger = new();

  // idle controls, set per phase by the stimulus
  bit src_gap_en;       // pixel side idles for a random draw before each transaction
  bit snk_pause_en;     // pulse side stalls for a random draw before each transaction
  int hold_off_cycles;  // one-shot long stall, taken by the pulse side
  int long_holds;
  int settings_count;
  int cycle_count;

  // hard stop if the run hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pulse pairs still due",
               cycle_count, ledger.due_pulses.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Pulse side: random stalls, one long hold-off, in-order matching
  // --------------------------------------------------------------------------
  initial begin
    int     stall;
    pulse_t got;
    pulse_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_off_cycles > 0) begin
        // long hold: the chain and scale register fill, pixel ready drops
        stall = hold_off_cycles;
        hold_off_cycles = 0;
        long_holds++;
      end else begin
        stall = snk_pause_en ? $urandom_range(0, 6) : 0;
      end
      if (stall > 0) begin
        pulse_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pulse_ch.ready <= 1'b1;
      do @(posedge clk); while (!pulse_ch.valid);
      got.high_ticks = pulse_ch.high_ticks;
      got.low_ticks  = pulse_ch.low_ticks;
      got.bit_value  = pulse_ch.bit_value;
      got.run_end    = pulse_ch.run_end;
      ledger.match_pulse(got);
    end
  end

  // --------------------------------------------------------------------------
  // Pixel side and register port
  // --------------------------------------------------------------------------

  // APB write (setup, access), read back (setup, access), then idle with psel
  // low so back-to-back writes never assign psel twice in one step
  task reg_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    logic [DATA_W-1:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    ledger.write_reg(idx, data);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    want = ledger.read_reg(idx);
    if (prdata !== want)
      ledger.report($sformatf("register %0d reads %0h, want %0h", idx, prdata, want));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // full register set plus both spare slots; caller passes raw bus words
  task write_settings(input logic [DATA_W-1:0] bright, input logic [DATA_W-1:0] zh,
                      input logic [DATA_W-1:0] zl, input logic [DATA_W-1:0] oh,
                      input logic [DATA_W-1:0] ol, input logic [DATA_W-1:0] lt);
    reg_write(REG_BRIGHTNESS, bright);
    reg_write(REG_ZERO_HIGH, zh);
    reg_write(REG_ZERO_LOW, zl);
    reg_write(REG_ONE_HIGH, oh);
    reg_write(REG_ONE_LOW, ol);
    reg_write(REG_LATCH, lt);
    reg_write(REG_SPARE_LO, $urandom());
    reg_write(REG_SPARE_HI, $urandom());
    settings_count++;
  endtask

  // tick word: extremes and short values often, junk above bit 14 always
  function logic [DATA_W-1:0] pick_ticks();
    logic [DATA_W-1:0] junk;
    junk = $urandom() & ~((1 << TICK_W) - 1);
    case ($urandom_range(0, 7))
      0:       return junk;
      1:       return junk | ((1 << TICK_W) - 1);
      2:       return junk | $urandom_range(0, 40);
      default: return $urandom();
    endcase
  endfunction

  function logic [DATA_W-1:0] pick_brightness();
    logic [DATA_W-1:0] junk;
    junk = $urandom() & ~((1 << CHAN_W) - 1);
    case ($urandom_range(0, 5))
      0:       return junk;
      1:       return junk | 255;
      2:       return junk | 1;
      default: return $urandom();
    endcase
  endfunction

  function pixel_t mk_pixel(int r, int g, int b, int last);
    pixel_t px;
    px.red        = CHAN_W'(r);
    px.green      = CHAN_W'(g);
    px.blue       = CHAN_W'(b);
    px.last_pixel = 1'(last);
    return px;
  endfunction

  // valid stays high between back-to-back pixels; lowered only for a gap
  task send_pixel(input pixel_t px);
    int gap;
    gap = src_gap_en ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_ch.valid      <= 1'b1;
    pix_ch.red        <= px.red;
    pix_ch.green      <= px.green;
    pix_ch.blue       <= px.blue;
    pix_ch.last_pixel <= px.last_pixel;
    do @(posedge clk); while (!pix_ch.ready);
    ledger.log_pixel(px);
  endtask

  // called right after the last pixel transaction of a phase
  task drain();
    pix_ch.valid <= 1'b0;
    do @(posedge clk); while (ledger.due_pulses.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // mostly whole frames (last flag on the final pixel), some loose pixels
  task random_traffic(input int count);
    int sent;
    int len;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 3) == 0) begin
        send_pixel(mk_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                            $urandom_range(0, 255), $urandom_range(0, 1)));
        sent++;
      end else begin
        len = $urandom_range(1, 10);
        for (int i = 0; i < len; i++)
          send_pixel(mk_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                              $urandom_range(0, 255), int'(i == len - 1)));
        sent += len;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst               <= 1'b1;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    pix_ch.valid      <= 1'b0;
    pix_ch.red        <= '0;
    pix_ch.green      <= '0;
    pix_ch.blue       <= '0;
    pix_ch.last_pixel <= 1'b0;
    src_gap_en   = 1'b1;
    snk_pause_en = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings, black, full white with latch, mixed bytes
    send_pixel(mk_pixel(0, 0, 0, 0));
    send_pixel(mk_pixel(255, 255, 255, 1));
    send_pixel(mk_pixel(8'hA5, 8'h3C, 8'hF0, 0));
    drain();

    // full brightness, zero bits 0/max, one bits max/0, zero latch
    write_settings(32'hFFFF_FFFF, 32'hFFFF_8000, 32'h0000_7FFF,
                   32'hFFFF_FFFF, 32'h1234_0000, 32'h0000_0000);
    send_pixel(mk_pixel(255, 255, 255, 1));
    send_pixel(mk_pixel(0, 0, 0, 1));
    send_pixel(mk_pixel(8'hAA, 8'h55, 8'h80, 0));
    send_pixel(mk_pixel(8'h55, 8'hAA, 8'h01, 0));
    for (int k = 0; k < CHAN_W; k += 2)
      send_pixel(mk_pixel(1 << k, 1 << (k + 1), 255 - (1 << k), (k >> 1) & 1));
    drain();

    // half brightness with the tick extremes swapped, max latch
    write_settings(32'h0000_0080, 32'h0000_7FFF, 32'h0000_0000,
                   32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_7FFF);
    send_pixel(mk_pixel(255, 0, 128, 1));
    send_pixel(mk_pixel(1, 254, 127, 0));
    drain();

    // brightness zero (junk above the byte): every bit encodes as zero
    write_settings(32'hFFFF_FF00, 32'd3, 32'd5, 32'd11, 32'd13, 32'd77);
    send_pixel(mk_pixel(255, 255, 255, 1));
    send_pixel(mk_pixel(8'h80, 8'h7F, 8'h01, 0));
    drain();

    // random phases: fresh settings each, varied idling, one long hold-off
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      write_settings(pick_brightness(), pick_ticks(), pick_ticks(),
                     pick_ticks(), pick_ticks(), pick_ticks());
      src_gap_en   = (ph % 3) != 1;
      snk_pause_en = (ph % 2) == 0;
      if (ph == 3) begin
        // pixel side runs flat out while the pulse side sits still
        src_gap_en      = 1'b0;
        hold_off_cycles = LONG_HOLD;
      end
      random_traffic(PHASE_PIXELS);
      drain();
    end

    // let any stray pulse show up before the verdict
    repeat (BITS_PER_PIXEL + 8) @(posedge clk);

    $display("run: %0d pixels (%0d frame ends), %0d pulse pairs, %0d register sets",
             ledger.pixels, ledger.latched, ledger.pulses, settings_count);
    $display("     brightness/tick extremes, spare-slot writes, %0d long hold-off(s)",
             long_holds);
    if (ledger.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", ledger.mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
